// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the timestamp parser RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/iso8601_ts_pkg.sv -----
// ---------------------------------------------------------------------------
// iso8601_ts_pkg
// Types, constants and position tables of the timestamp parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package iso8601_ts_pkg;

  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = 1;
  localparam int unsigned QCntW    = 2;
  localparam int unsigned PosW     = 5;
  localparam int unsigned AccW     = 14;
  localparam logic [PosW-1:0] LastPos = 5'd19;

  typedef enum logic [2:0] {
    SEP_NONE,
    SEP_DASH,
    SEP_TEE,
    SEP_COLON,
    SEP_ZED
  } sep_e;

  // classified character, front to back
  typedef struct packed {
    logic       first;
    logic       is_digit;
    logic [3:0] digit;
    sep_e       sep;
  } item_t;

  // result item, ok in the lowest bit
  typedef struct packed {
    logic [5:0]  second_of_minute;
    logic [5:0]  minute_of_hour;
    logic [4:0]  hour_of_day;
    logic [4:0]  day_of_month;
    logic [3:0]  month_index;
    logic [12:0] years_since_1900;
    logic        ok;
  } result_t;

  function automatic sep_e sep_at(input logic [PosW-1:0] pos);
    sep_e s;
    case (pos)
      5'd4, 5'd7:   s = SEP_DASH;
      5'd10:        s = SEP_TEE;
      5'd13, 5'd16: s = SEP_COLON;
      5'd19:        s = SEP_ZED;
      default:      s = SEP_NONE;
    endcase
    return s;
  endfunction

  function automatic logic field_start(input logic [PosW-1:0] pos);
    return (pos == 5'd0) || (pos == 5'd5) || (pos == 5'd8) ||
           (pos == 5'd11) || (pos == 5'd14) || (pos == 5'd17);
  endfunction

endpackage

// ----- design/iso8601_ts_queue.sv -----
// ---------------------------------------------------------------------------
// iso8601_ts_queue
// Two-entry register queue of classified items between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iso8601_ts_queue
  import iso8601_ts_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  item_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != QCntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= QCntW'(QDepth))
  `ASSERT_IMPL(a_ptr_track, clk_i, rst_ni, cnt_q == '0 || cnt_q == QCntW'(QDepth),
               wr_ptr_q == rd_ptr_q)

endmodule

// ----- design/iso8601_ts_front.sv -----
// ---------------------------------------------------------------------------
// iso8601_ts_front
// Input side: accepts characters and classifies them as digit or separator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module iso8601_ts_front
  import iso8601_ts_pkg::*;
(
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       s_axis_tuser,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output item_t      push_item_o
);

  assign s_axis_tready = push_ready_i;
  assign push_valid_o  = s_axis_tvalid;

  always_comb begin
    push_item_o.first    = s_axis_tuser;
    push_item_o.is_digit = (s_axis_tdata >= 8'h30) && (s_axis_tdata <= 8'h39);
    // low nibble of '0'..'9' is the digit value
    push_item_o.digit    = s_axis_tdata[3:0];
    case (s_axis_tdata)
      8'h2D:   push_item_o.sep = SEP_DASH;
      8'h54:   push_item_o.sep = SEP_TEE;
      8'h3A:   push_item_o.sep = SEP_COLON;
      8'h5A:   push_item_o.sep = SEP_ZED;
      default: push_item_o.sep = SEP_NONE;
    endcase
  end

endmodule

// ----- design/iso8601_ts_back.sv -----
// ---------------------------------------------------------------------------
// iso8601_ts_back
// Parse engine: position counter, decimal accumulator, range checks and
// the registered result stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iso8601_ts_back
  import iso8601_ts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  item_t       pop_item_i,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata
);

  logic [PosW-1:0] pos_q, pos_d;
  logic            fin_q, fin_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [12:0]     year_q, year_d;
  logic [3:0]      month_q, month_d;
  logic [4:0]      day_q, day_d;
  logic [4:0]      hour_q, hour_d;
  logic [5:0]      minute_q, minute_d;
  logic            out_valid_q, out_valid_d;
  result_t         out_q, out_d;

  logic            pop, active;
  logic [PosW-1:0] pos;
  sep_e            exp_sep;
  logic [AccW-1:0] acc_new;
  logic            fail, good, emit;

  assign pop_ready_o   = !out_valid_q || m_axis_tready;
  assign pop           = pop_valid_i && pop_ready_o;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    active  = pop && (pop_item_i.first || !fin_q);
    pos     = pop_item_i.first ? '0 : pos_q;
    exp_sep = sep_at(pos);
    acc_new = field_start(pos) ? AccW'(pop_item_i.digit)
            : AccW'((17'(acc_q) << 3) + (17'(acc_q) << 1) + 17'(pop_item_i.digit));
    fail    = 1'b0;
    good    = 1'b0;

    pos_d    = pos_q;
    fin_d    = fin_q;
    acc_d    = acc_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;

    if (active) begin
      if (exp_sep != SEP_NONE) begin
        if (pop_item_i.sep != exp_sep) begin
          fail = 1'b1;
        end else if (pos == LastPos) begin
          good = 1'b1;
        end
      end else if (!pop_item_i.is_digit) begin
        fail = 1'b1;
      end else begin
        acc_d = acc_new;
        case (pos)
          5'd3: begin
            fail   = (acc_new < 14'd1900);
            year_d = 13'(acc_new - 14'd1900);
          end
          5'd6: begin
            fail    = (acc_new == '0) || (acc_new > 14'd12);
            month_d = 4'(acc_new - 14'd1);
          end
          5'd9: begin
            fail  = (acc_new == '0) || (acc_new > 14'd31);
            day_d = acc_new[4:0];
          end
          5'd12: begin
            fail   = (acc_new > 14'd23);
            hour_d = acc_new[4:0];
          end
          5'd15: begin
            fail     = (acc_new > 14'd59);
            minute_d = acc_new[5:0];
          end
          5'd18: begin
            fail = (acc_new > 14'd59);
          end
          default: begin
          end
        endcase
      end
      if (fail || good) begin
        fin_d = 1'b1;
      end else begin
        fin_d = 1'b0;
        pos_d = pos + 1'b1;
      end
      if (pop_item_i.first && (fail || good)) begin
        pos_d = '0;
      end
    end
    emit = active && (fail || good);

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d          = 1'b1;
      out_d                = '0;
      out_d.ok             = good;
      if (good) begin
        out_d.years_since_1900 = year_q;
        out_d.month_index      = month_q;
        out_d.day_of_month     = day_q;
        out_d.hour_of_day      = hour_q;
        out_d.minute_of_hour   = minute_q;
        out_d.second_of_minute = acc_q[5:0];
      end
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      fin_q       <= 1'b1;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      fin_q       <= fin_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    year_q   <= year_d;
    month_q  <= month_d;
    day_q    <= day_d;
    hour_q   <= hour_d;
    minute_q <= minute_d;
    out_q    <= out_d;
  end

  `ASSERT_ALWAYS(a_pos_range, clk_i, rst_ni, pos_q <= LastPos)
  `ASSERT_IMPL(a_ok_ranges, clk_i, rst_ni, out_valid_q && out_q.ok,
               out_q.month_index <= 4'd11 && out_q.hour_of_day <= 5'd23 &&
               out_q.minute_of_hour <= 6'd59 && out_q.second_of_minute <= 6'd59)
  `ASSERT_IMPL(a_fail_zero, clk_i, rst_ni, out_valid_q && !out_q.ok,
               out_q == result_t'('0))
  `ASSERT_NEXT(a_emit_done, clk_i, rst_ni, emit, fin_q && out_valid_q)

endmodule

// ----- design/iso8601_timestamp_parser_top.sv -----
// ---------------------------------------------------------------------------
// iso8601_timestamp_parser_top
// Character-serial parser for UTC timestamps YYYY-MM-DDTHH:MM:SSZ.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one ASCII character per item in tdata; tuser flags the
//   first character of a timestamp and restarts parsing. Without a flagged
//   item the block stays idle and drops characters (also after reset).
//   m_axis carries one result per timestamp, on the closing 'Z' or on the
//   first bad character; later characters are dropped until the next flag.
//   Throughput is one character per cycle while m_axis is not stalled, set
//   by the combinational compare and multiply-by-ten step of the parse engine.
//   An accepted character is stored in the two-entry classify queue; the
//   result that it completes is then held in the result register.
//   When the receiver stalls, the result register holds its item and the
//   queue absorbs up to two characters before s_axis_tready drops.
//   Reset clears the queue and the output and leaves the parser idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module iso8601_timestamp_parser_top
  import iso8601_ts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // character[7:0]
  input  logic        s_axis_tuser,   // first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // ok, years_since_1900[13], month_index[4],
                                      // day_of_month[5], hour_of_day[5],
                                      // minute_of_hour[6], second_of_minute[6]
);

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  iso8601_ts_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_item_o   (push_item)
  );

  iso8601_ts_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  iso8601_ts_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_item_i    (pop_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
